// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer slot pool package
// Shared constants, operation and status codes, and the request record that
// travels along the row of slot cells.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned FIELD_SLOTS   = 16;
  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned MASK_W        = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_CREATE  = 2'd1,
    OP_RESET   = 2'd2,
    OP_DESTROY = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [DELAY_W-1:0] delay;
    logic               rep;
    status_t            status;
    logic [IDX_W-1:0]   created;
    logic [MASK_W-1:0]  fired;
  } pkt_t;

endpackage

// ===== rtl/tsp_req_if.sv =====
// ----------------------------------------------------------------------------
// Timer slot pool request channel
// Valid/ready channel that carries one operation request into the pool.
// ----------------------------------------------------------------------------
interface tsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  timer_index;
  logic [31:0] delay;
  logic        repeat_req;

  modport source (output valid, operation, timer_index, delay, repeat_req, input ready);
  modport sink (input valid, operation, timer_index, delay, repeat_req, output ready);
endinterface

// ===== rtl/tsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Timer slot pool response channel
// Valid/ready channel that carries one result per request out of the pool.
// ----------------------------------------------------------------------------
interface tsp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  created_index;
  logic [15:0] fired_mask;

  modport source (output valid, status, created_index, fired_mask, input ready);
  modport sink (input valid, status, created_index, fired_mask, output ready);
endinterface

// ===== rtl/timer_slot_pool.sv =====
// ----------------------------------------------------------------------------
// Timer slot pool
// Pool of timer slots that serves create, reset, destroy and tick requests.
// ----------------------------------------------------------------------------
// Each request walks a row of slot cells, one cell per clock. The row has
// USABLE cells, where USABLE is the smaller of NUM_SLOTS and 16, and the
// default is 16 slots. The pool works on one request at a time and is ready
// again once the previous result has moved into the output register, even if
// that result has not been taken yet. Create picks the lowest free slot, and
// tick fires every due slot in the same pass.
module timer_slot_pool
  import tsp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  tsp_req_if.sink   req,
  tsp_rsp_if.source rsp
);

  localparam int unsigned USABLE = (NUM_SLOTS < FIELD_SLOTS) ? NUM_SLOTS : FIELD_SLOTS;

  logic    chain_valid [USABLE+1];
  pkt_t    chain_pkt   [USABLE+1];
  logic    accept;
  logic    busy;
  logic    fin_valid;
  pkt_t    fin_pkt;
  logic    fin_move;
  logic    out_valid;
  status_t out_status;
  logic [IDX_W-1:0]  out_created;
  logic [MASK_W-1:0] out_fired;
  status_t init_status;

  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  always_comb begin
    case (op_t'(req.operation))
      OP_TICK:   init_status = ST_DONE;
      OP_CREATE: init_status = ST_FULL;
      default:   init_status = ST_NOT_ALLOC;
    endcase
  end

  assign chain_valid[0]       = accept;
  assign chain_pkt[0].op      = op_t'(req.operation);
  assign chain_pkt[0].idx     = req.timer_index;
  assign chain_pkt[0].delay   = req.delay;
  assign chain_pkt[0].rep     = req.repeat_req;
  assign chain_pkt[0].status  = init_status;
  assign chain_pkt[0].created = '0;
  assign chain_pkt[0].fired   = '0;

  for (genvar i = 0; i < USABLE; i++) begin : g_cell
    tsp_cell #(
      .SLOT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_pkt    (chain_pkt[i]),
      .out_valid (chain_valid[i+1]),
      .out_pkt   (chain_pkt[i+1])
    );
  end

  assign fin_move = fin_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fin_move) begin
        busy <= 1'b0;
      end
      if (chain_valid[USABLE]) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[USABLE]) begin
      fin_pkt <= chain_pkt[USABLE];
    end
    if (fin_move) begin
      out_status  <= fin_pkt.status;
      out_created <= fin_pkt.created;
      out_fired   <= fin_pkt.fired;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.created_index = out_created;
  assign rsp.fired_mask    = out_fired;

endmodule

// ===== rtl/tsp_cell.sv =====
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one timer slot and applies the passing request to it, then registers
// the updated request record for the next cell.
// ----------------------------------------------------------------------------
module tsp_cell
  import tsp_pkg::*;
#(
  parameter int unsigned SLOT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  pkt_t in_pkt,
  output logic out_valid,
  output pkt_t out_pkt
);

  localparam logic [IDX_W-1:0] ID = IDX_W'(SLOT);

  logic               in_use;
  logic               in_use_next;
  logic [DELAY_W-1:0] slot_delay;
  logic [DELAY_W-1:0] slot_delay_next;
  logic [DELAY_W-1:0] slot_elapsed;
  logic [DELAY_W-1:0] slot_elapsed_next;
  logic               slot_repeat;
  logic               slot_repeat_next;
  pkt_t               pkt_next;

  always_comb begin
    in_use_next       = in_use;
    slot_delay_next   = slot_delay;
    slot_elapsed_next = slot_elapsed;
    slot_repeat_next  = slot_repeat;
    pkt_next          = in_pkt;
    case (in_pkt.op)
      OP_TICK: begin
        if (in_use && (slot_delay != '0)) begin
          slot_elapsed_next = (&slot_elapsed) ? slot_elapsed : slot_elapsed + 1'b1;
          if (slot_elapsed >= slot_delay) begin
            pkt_next.fired[SLOT] = 1'b1;
            if (slot_repeat) begin
              slot_elapsed_next = '0;
            end else begin
              slot_delay_next = '0;
            end
          end
        end
      end
      OP_CREATE: begin
        if (!in_use && (in_pkt.status == ST_FULL)) begin
          in_use_next       = 1'b1;
          slot_delay_next   = in_pkt.delay;
          slot_elapsed_next = '0;
          slot_repeat_next  = in_pkt.rep;
          pkt_next.status   = ST_DONE;
          pkt_next.created  = ID;
        end
      end
      OP_RESET: begin
        if (in_use && (in_pkt.idx == ID)) begin
          slot_delay_next   = in_pkt.delay;
          slot_elapsed_next = '0;
          pkt_next.status   = ST_DONE;
        end
      end
      OP_DESTROY: begin
        if (in_use && (in_pkt.idx == ID)) begin
          in_use_next     = 1'b0;
          pkt_next.status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid) begin
        in_use <= in_use_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      slot_delay   <= slot_delay_next;
      slot_elapsed <= slot_elapsed_next;
      slot_repeat  <= slot_repeat_next;
      out_pkt      <= pkt_next;
    end
  end

endmodule

// ===== rtl/tsp_checker.sv =====
// ----------------------------------------------------------------------------
// Timer slot pool checker
// Port-level checks of the pool, attached to every instance of the top level.
// ----------------------------------------------------------------------------
module tsp_checker
  import tsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [3:0]  rsp_created_index,
  input logic [15:0] rsp_fired_mask
);

  // The pool serves one request at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another was in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
      && $stable(rsp_created_index) && $stable(rsp_fired_mask)))
    else $error("stalled response changed");

  a_created_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_created_index == '0))
    else $error("slot index reported with an error status");

  a_fired_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_fired_mask != '0)) |-> (rsp_status == ST_DONE))
    else $error("fired slots reported with an error status");

endmodule

bind timer_slot_pool tsp_checker u_tsp_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_created_index (rsp.created_index),
  .rsp_fired_mask    (rsp.fired_mask)
);
